// ----- sv/pfe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared widths, register indexes, status codes and payload types for the
// Plummer sphere potential and force pipeline.
// ----------------------------------------------------------------------------
package pfe_pkg;

    localparam int unsigned COORD_W   = 32;
    localparam int unsigned CFG_W     = 32;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned QUOT_W    = 32;
    localparam int unsigned RAD_W     = 66;   // r^2 + x^2 + y^2 + z^2
    localparam int unsigned ROOT_W    = 33;   // floor(sqrt) of the above
    localparam int unsigned DS_W      = 99;   // rad * root

    localparam logic [CFG_W-1:0] CFG_RESET_ONE = 32'h0001_0000;

    localparam logic [CFG_IDX_W-1:0] REG_MASS        = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CORE_RADIUS = 1'b1;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_SAT  = 2'd1;
    localparam logic [1:0] STATUS_SING = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
    } t_pos;

    typedef struct packed {
        logic signed [COORD_W-1:0] potential;
        logic signed [COORD_W-1:0] acc_x;
        logic signed [COORD_W-1:0] acc_y;
        logic signed [COORD_W-1:0] acc_z;
        logic [1:0]                status;
    } t_result;

endpackage

// ----- sv/pfe_delay.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_delay
// Fixed-depth shift line that carries a valid bit and its sideband data
// alongside the arithmetic units of the pipeline.
// ----------------------------------------------------------------------------
module pfe_delay #(
    parameter int unsigned DATA_W = 1,
    parameter int unsigned DEPTH  = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data
);

    logic              r_valid [DEPTH];
    logic [DATA_W-1:0] r_data  [DEPTH];

    for (genvar j = 0; j < DEPTH; j++) begin : g_tap
        if (j == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[j] <= 1'b0;
                end else begin
                    r_valid[j] <= i_valid;
                end
                r_data[j] <= i_data;
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[j] <= 1'b0;
                end else begin
                    r_valid[j] <= r_valid[j-1];
                end
                r_data[j] <= r_data[j-1];
            end
        end
    end

    assign o_valid = r_valid[DEPTH-1];
    assign o_data  = r_data[DEPTH-1];

endmodule

// ----- sv/pfe_isqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_isqrt
// Pipelined integer square root, one root bit per stage, restoring form.
// The root is floor(sqrt(i_rad)), taken from the last of ROOT_W stages.
// ----------------------------------------------------------------------------
module pfe_isqrt (
    input  logic                        i_clk,
    input  logic [pfe_pkg::RAD_W-1:0]   i_rad,
    output logic [pfe_pkg::ROOT_W-1:0]  o_root
);
    import pfe_pkg::*;

    localparam int unsigned TRIAL_W = RAD_W + 1;

    logic [RAD_W-1:0]  r_rem  [ROOT_W-1];
    logic [ROOT_W-1:0] r_root [ROOT_W];

    for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
        localparam int unsigned BIT = ROOT_W - 1 - j;

        logic [RAD_W-1:0]   rem_in;
        logic [ROOT_W-1:0]  root_in;
        logic [TRIAL_W-1:0] trial;
        logic               take;

        if (j == 0) begin : g_first
            assign rem_in  = i_rad;
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = r_rem[j-1];
            assign root_in = r_root[j-1];
        end

        // (root + 2^b)^2 - root^2 with root holding only bits above b
        assign trial = ({{(TRIAL_W-ROOT_W){1'b0}}, root_in} << (BIT + 1))
                     | (TRIAL_W'(1) << (2 * BIT));
        assign take  = {1'b0, rem_in} >= trial;

        always_ff @(posedge i_clk) begin
            r_root[j] <= take ? (root_in | (ROOT_W'(1) << BIT)) : root_in;
        end

        if (j < ROOT_W - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                r_rem[j] <= take ? (rem_in - trial[RAD_W-1:0]) : rem_in;
            end
        end
    end

    assign o_root = r_root[ROOT_W-1];

endmodule

// ----- sv/pfe_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_div
// Pipelined restoring divider, one quotient bit per stage. The numerator
// is {i_num_hi, i_num_lo}; with i_num_hi below i_den the quotient fits
// QUOT_W bits and is taken from the last of QUOT_W stages.
// ----------------------------------------------------------------------------
module pfe_div #(
    parameter int unsigned DEN_W = 33
) (
    input  logic                       i_clk,
    input  logic [DEN_W-1:0]           i_num_hi,
    input  logic [pfe_pkg::QUOT_W-1:0] i_num_lo,
    input  logic [DEN_W-1:0]           i_den,
    output logic [pfe_pkg::QUOT_W-1:0] o_quot
);
    import pfe_pkg::*;

    logic [DEN_W-1:0]  r_rem  [QUOT_W-1];
    logic [DEN_W-1:0]  r_den  [QUOT_W-1];
    logic [QUOT_W-1:0] r_lo   [QUOT_W-1];
    logic [QUOT_W-1:0] r_quot [QUOT_W];

    for (genvar j = 0; j < QUOT_W; j++) begin : g_stage
        logic [DEN_W-1:0]  rem_in;
        logic [DEN_W-1:0]  den_in;
        logic [QUOT_W-1:0] lo_in;
        logic [QUOT_W-1:0] quot_in;
        logic [DEN_W:0]    shifted;
        logic [DEN_W:0]    diff;
        logic              take;

        if (j == 0) begin : g_first
            assign rem_in  = i_num_hi;
            assign den_in  = i_den;
            assign lo_in   = i_num_lo;
            assign quot_in = '0;
        end else begin : g_next
            assign rem_in  = r_rem[j-1];
            assign den_in  = r_den[j-1];
            assign lo_in   = r_lo[j-1];
            assign quot_in = r_quot[j-1];
        end

        assign shifted = {rem_in, lo_in[QUOT_W-1]};
        assign diff    = shifted - {1'b0, den_in};
        assign take    = shifted >= {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            r_quot[j] <= {quot_in[QUOT_W-2:0], take};
        end

        if (j < QUOT_W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_rem[j] <= take ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
                r_den[j] <= den_in;
                r_lo[j]  <= {lo_in[QUOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_quot = r_quot[QUOT_W-1];

endmodule

// ----- sv/plummer_force_eval.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plummer_force_eval
// Plummer sphere potential and acceleration for one Q16.16 position.
// ----------------------------------------------------------------------------
// Usage:
//   A position on i_pos is taken at every rising edge with start high; busy
//   is held low, so a new position may follow in every cycle.
//   The result for it comes out on o_result with o_done high for one cycle,
//   in input order.
//   Throughput is one position per cycle. Latency is set by the square root
//   (33 stages, one root bit each) and the dividers (32 stages, one quotient
//   bit each), plus three input stages, two for the rad * root product and
//   the output register.
//   The receiver cannot stall, so the pipeline never holds.
//   Mass and core radius are written via i_cfg_we / i_cfg_idx / i_cfg_data
//   only while no transaction is in flight: the user's duty, not enforced.
//   Synchronous reset clears every valid bit, drops o_done and loads mass
//   and core radius with 1.0.
// ----------------------------------------------------------------------------
module plummer_force_eval (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  pfe_pkg::t_pos                 i_pos,
    output logic                          busy,
    input  logic                          i_cfg_we,
    input  logic [pfe_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pfe_pkg::CFG_W-1:0]     i_cfg_data,
    output logic                          o_done,
    output pfe_pkg::t_result              o_result
);
    import pfe_pkg::*;

    localparam int unsigned PROD_W = 2 * COORD_W;
    localparam int unsigned HALF_W = RAD_W / 2;
    localparam int unsigned PP_W   = HALF_W + ROOT_W;

    typedef struct packed {
        logic [RAD_W-1:0]             rad;
        logic [2:0][PROD_W-1:0]       mp;
        logic [2:0]                   neg;
        logic                         sing;
    } t_side_a;

    typedef struct packed {
        logic [2:0][PROD_W-1:0]       mp;
        logic [2:0]                   neg;
        logic                         sing;
    } t_side_b;

    typedef struct packed {
        logic [2:0]                   ovf_acc;
        logic                         ovf_pot;
        logic [2:0]                   neg;
        logic                         sing;
    } t_side_c;

    // configuration
    logic [CFG_W-1:0] r_mass;
    logic [CFG_W-1:0] r_core_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mass        <= CFG_RESET_ONE;
            r_core_radius <= CFG_RESET_ONE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MASS:        r_mass        <= i_cfg_data;
                REG_CORE_RADIUS: r_core_radius <= i_cfg_data;
            endcase
        end
    end

    assign busy = 1'b0;

    // stage 1: squares
    logic signed [PROD_W-1:0] sq_x, sq_y, sq_z;
    logic [PROD_W-1:0]        r_sq_r, r_sq_x, r_sq_y, r_sq_z;
    t_pos                     r_pos1;
    logic                     r_v1;

    assign sq_x = PROD_W'(i_pos.pos_x) * PROD_W'(i_pos.pos_x);
    assign sq_y = PROD_W'(i_pos.pos_y) * PROD_W'(i_pos.pos_y);
    assign sq_z = PROD_W'(i_pos.pos_z) * PROD_W'(i_pos.pos_z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
        end
        r_sq_r <= PROD_W'(r_core_radius) * PROD_W'(r_core_radius);
        r_sq_x <= sq_x;
        r_sq_y <= sq_y;
        r_sq_z <= sq_z;
        r_pos1 <= i_pos;
    end

    // stage 2: partial sums, magnitudes
    logic [COORD_W-1:0] coord [3];
    logic [PROD_W:0]    r_sum_a, r_sum_b;
    logic [COORD_W-1:0] r_mag2 [3];
    logic [2:0]         r_neg2;
    logic               r_v2;

    assign coord[0] = r_pos1.pos_x;
    assign coord[1] = r_pos1.pos_y;
    assign coord[2] = r_pos1.pos_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_sum_a <= {1'b0, r_sq_r} + {1'b0, r_sq_x};
        r_sum_b <= {1'b0, r_sq_y} + {1'b0, r_sq_z};
        for (int i = 0; i < 3; i++) begin
            r_neg2[i] <= coord[i][COORD_W-1];
            r_mag2[i] <= coord[i][COORD_W-1] ? (~coord[i] + 32'd1) : coord[i];
        end
    end

    // stage 3: rad = r^2 + |p|^2, mass * |p|
    logic [RAD_W-1:0]  r_rad3;
    logic [PROD_W-1:0] r_mp3 [3];
    logic [2:0]        r_neg3;
    logic              r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
        r_rad3 <= {1'b0, r_sum_a} + {1'b0, r_sum_b};
        r_neg3 <= r_neg2;
        for (int i = 0; i < 3; i++) begin
            r_mp3[i] <= PROD_W'(r_mass) * PROD_W'(r_mag2[i]);
        end
    end

    // square root with sideband alongside
    t_side_a            side_a_in, side_a_out;
    logic               v36;
    logic [ROOT_W-1:0]  root;

    always_comb begin
        side_a_in.rad  = r_rad3;
        side_a_in.neg  = r_neg3;
        side_a_in.sing = (r_rad3 == '0);
        for (int i = 0; i < 3; i++) begin
            side_a_in.mp[i] = r_mp3[i];
        end
    end

    pfe_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_rad  (r_rad3),
        .o_root (root)
    );

    pfe_delay #(
        .DATA_W ($bits(t_side_a)),
        .DEPTH  (ROOT_W)
    ) u_line_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v3),
        .i_data  (side_a_in),
        .o_valid (v36),
        .o_data  (side_a_out)
    );

    // rad * root in two partial products
    logic [PP_W-1:0]   r_pp_lo, r_pp_hi;
    logic [ROOT_W-1:0] r_root37, r_root38;
    t_side_b           r_side37, r_side38;
    logic              r_v37, r_v38;
    logic [DS_W-1:0]   r_ds;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v37 <= 1'b0;
            r_v38 <= 1'b0;
        end else begin
            r_v37 <= v36;
            r_v38 <= r_v37;
        end
        r_pp_lo       <= PP_W'(side_a_out.rad[HALF_W-1:0]) * PP_W'(root);
        r_pp_hi       <= PP_W'(side_a_out.rad[RAD_W-1:HALF_W]) * PP_W'(root);
        r_root37      <= root;
        r_side37.mp   <= side_a_out.mp;
        r_side37.neg  <= side_a_out.neg;
        r_side37.sing <= side_a_out.sing;
        r_ds          <= {{(DS_W-PP_W){1'b0}}, r_pp_lo} + {r_pp_hi, {HALF_W{1'b0}}};
        r_root38      <= r_root37;
        r_side38      <= r_side37;
    end

    // dividers: potential = m*2^16 / root, acc = m*|p|*2^32 / (rad * root)
    t_side_c            side_c_in, side_c_out;
    logic               v70;
    logic [QUOT_W-1:0]  quot_pot;
    logic [QUOT_W-1:0]  quot_acc [3];

    always_comb begin
        side_c_in.ovf_pot = {{(ROOT_W-16){1'b0}}, r_mass[CFG_W-1:16]} >= r_root38;
        side_c_in.neg     = r_side38.neg;
        side_c_in.sing    = r_side38.sing;
        for (int i = 0; i < 3; i++) begin
            side_c_in.ovf_acc[i] = {{(DS_W-PROD_W){1'b0}}, r_side38.mp[i]} >= r_ds;
        end
    end

    pfe_div #(
        .DEN_W (ROOT_W)
    ) u_div_pot (
        .i_clk    (i_clk),
        .i_num_hi ({{(ROOT_W-16){1'b0}}, r_mass[CFG_W-1:16]}),
        .i_num_lo ({r_mass[15:0], 16'd0}),
        .i_den    (r_root38),
        .o_quot   (quot_pot)
    );

    for (genvar g = 0; g < 3; g++) begin : g_acc
        pfe_div #(
            .DEN_W (DS_W)
        ) u_div_acc (
            .i_clk    (i_clk),
            .i_num_hi ({{(DS_W-PROD_W){1'b0}}, r_side38.mp[g]}),
            .i_num_lo ('0),
            .i_den    (r_ds),
            .o_quot   (quot_acc[g])
        );
    end

    pfe_delay #(
        .DATA_W ($bits(t_side_c)),
        .DEPTH  (QUOT_W)
    ) u_line_c (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v38),
        .i_data  (side_c_in),
        .o_valid (v70),
        .o_data  (side_c_out)
    );

    // saturation, signs, status
    t_result            n_result;
    t_result            r_result;
    logic               r_done;

    always_comb begin
        logic              sat_pot;
        logic              sat_any;
        logic [QUOT_W-1:0] limit;
        logic [QUOT_W-1:0] mag;
        logic [QUOT_W-1:0] acc [3];

        sat_pot = side_c_out.ovf_pot || (quot_pot > 32'h8000_0000);
        sat_any = sat_pot;
        for (int i = 0; i < 3; i++) begin
            // a negative coordinate gives a positive result, one less headroom
            limit = side_c_out.neg[i] ? 32'h7FFF_FFFF : 32'h8000_0000;
            if (side_c_out.ovf_acc[i] || (quot_acc[i] > limit)) begin
                mag     = limit;
                sat_any = 1'b1;
            end else begin
                mag = quot_acc[i];
            end
            acc[i] = side_c_out.neg[i] ? mag : (32'd0 - mag);
        end

        if (side_c_out.sing) begin
            n_result.potential = 32'h8000_0000;
            n_result.acc_x     = '0;
            n_result.acc_y     = '0;
            n_result.acc_z     = '0;
            n_result.status    = STATUS_SING;
        end else begin
            n_result.potential = sat_pot ? 32'h8000_0000 : (32'd0 - quot_pot);
            n_result.acc_x     = acc[0];
            n_result.acc_y     = acc[1];
            n_result.acc_z     = acc[2];
            n_result.status    = sat_any ? STATUS_SAT : STATUS_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= v70;
        end
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule
